[rtl/sbmc_pkg.sv]
// Shared types, constants and small lookup functions for the bone matrix composer.
package sbmc_pkg;

    localparam int WORDS_PER_BONE = 12;
    localparam int BONE_SLOTS     = 64;   // codes of the 6-bit bone_index
    localparam int PROD_W         = 48;   // rounded s31.16 product of two s15.16 operands
    localparam int SUM_W          = 52;   // wide accumulator / rotation sums

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    // register map (word index, taken from paddr[2])
    localparam logic REG_BONE_COUNT = 1'b0;

    // slots of the quaternion product registers
    localparam logic [3:0] QP_XX = 4'd0;
    localparam logic [3:0] QP_YY = 4'd1;
    localparam logic [3:0] QP_ZZ = 4'd2;
    localparam logic [3:0] QP_XY = 4'd3;
    localparam logic [3:0] QP_XZ = 4'd4;
    localparam logic [3:0] QP_YZ = 4'd5;
    localparam logic [3:0] QP_WX = 4'd6;
    localparam logic [3:0] QP_WY = 4'd7;
    localparam logic [3:0] QP_WZ = 4'd8;

    // quaternion component slots
    localparam logic [1:0] Q_X = 2'd0;
    localparam logic [1:0] Q_Y = 2'd1;
    localparam logic [1:0] Q_Z = 2'd2;
    localparam logic [1:0] Q_W = 2'd3;

    localparam logic [1:0] K_TRANS = 2'd3;  // fourth term of each world word

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QMUL,
        ST_ROT,
        ST_LMUL,
        ST_WMUL,
        ST_WRITE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] rot_w;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [6:0]         parent_index;
        logic [5:0]         bone_index;
    } bone_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } mat_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [31:0] res;
        if ((x[SUM_W-1:31] == '0) || (x[SUM_W-1:31] == '1))
        begin
            res = x[31:0];
        end
        else if (x[SUM_W-1])
        begin
            res = 32'sh8000_0000;
        end
        else
        begin
            res = 32'sh7fff_ffff;
        end
        return res;
    endfunction

    // 1 - 2(u+v)
    function automatic logic signed [31:0] rot_diag(input logic signed [PROD_W-1:0] u,
                                                    input logic signed [PROD_W-1:0] v);
        logic signed [SUM_W-1:0] sum;
        sum = SUM_W'(u) + SUM_W'(v);
        return sat32(SUM_W'(ONE_Q16) - (sum <<< 1));
    endfunction

    // 2(u+v) or 2(u-v)
    function automatic logic signed [31:0] rot_off(input logic signed [PROD_W-1:0] u,
                                                   input logic signed [PROD_W-1:0] v,
                                                   input logic neg);
        logic signed [SUM_W-1:0] sum;
        if (neg)
        begin
            sum = SUM_W'(u) - SUM_W'(v);
        end
        else
        begin
            sum = SUM_W'(u) + SUM_W'(v);
        end
        return sat32(sum <<< 1);
    endfunction

    // operand selects for the nine quaternion products, in QP_* order
    function automatic logic [1:0] qa_sel(input logic [3:0] n);
        logic [1:0] res;
        unique case (n)
            QP_XX, QP_XY, QP_XZ: res = Q_X;
            QP_YY, QP_YZ:        res = Q_Y;
            QP_ZZ:               res = Q_Z;
            QP_WX, QP_WY, QP_WZ: res = Q_W;
            default:             res = Q_X;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] qb_sel(input logic [3:0] n);
        logic [1:0] res;
        unique case (n)
            QP_XX, QP_WX:        res = Q_X;
            QP_YY, QP_XY, QP_WY: res = Q_Y;
            QP_ZZ, QP_XZ, QP_YZ, QP_WZ: res = Q_Z;
            default:             res = Q_X;
        endcase
        return res;
    endfunction

    // matrix row of an output word (rotation words row-major, then translation)
    function automatic logic [1:0] row_of(input logic [3:0] w);
        logic [1:0] res;
        unique case (w)
            4'd0, 4'd1, 4'd2, 4'd9:  res = 2'd0;
            4'd3, 4'd4, 4'd5, 4'd10: res = 2'd1;
            4'd6, 4'd7, 4'd8, 4'd11: res = 2'd2;
            default:                 res = 2'd0;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] col_of(input logic [3:0] w);
        logic [1:0] res;
        unique case (w)
            4'd0, 4'd3, 4'd6: res = 2'd0;
            4'd1, 4'd4, 4'd7: res = 2'd1;
            4'd2, 4'd5, 4'd8: res = 2'd2;
            default:          res = 2'd0;
        endcase
        return res;
    endfunction

    function automatic logic is_trans(input logic [3:0] w);
        return (w >= 4'd9);
    endfunction

    // parent-matrix word read for term k of output word s[5:2]
    function automatic logic [3:0] mem_off(input logic [5:0] s);
        logic [1:0] k;
        logic [1:0] row;
        logic [3:0] res;
        k   = s[1:0];
        row = row_of(s[5:2]);
        if (k != K_TRANS)
        begin
            res = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, k};
        end
        else if (is_trans(s[5:2]))
        begin
            res = 4'd9 + {2'b00, row};
        end
        else
        begin
            res = 4'd0;
        end
        return res;
    endfunction

endpackage

[rtl/sbmc_if.sv]
// Valid/ready channel interfaces for bone items and world matrices.
interface sbmc_bone_if;
    logic            valid;
    logic            ready;
    sbmc_pkg::bone_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sbmc_mat_if;
    logic           valid;
    logic           ready;
    sbmc_pkg::mat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/skeleton_bone_matrix_compose.sv]
// Top level: bone transform to world matrix composer with sequencer and matrix store.
//
// Channels: bone (sink) carries scale, quaternion, translation, parent and
// bone index; mat (source) carries the 3x4 world matrix, one per bone.
// A transfer happens on a rising edge with valid and ready both high.
// The APB port holds bone_count at byte address 0; pready is always high.
//
// Each bone runs through one shared 32x32 multiplier: 9 quaternion products,
// 9 local products, and for a bone with a parent 48 products against the
// parent's stored matrix (read one word per cycle from the store), then
// the world matrix is written back into the store word by word.
// bone.ready is high only while idle, so one bone is in flight at a time.
// A finished matrix sits in the output register; the next bone is taken
// while it waits. If the receiver still stalls when the following bone is
// done, the sequencer holds before its output load.
// Reset clears control state and sets bone_count to 1; the matrix store is
// not cleared and a parent must be written before it is read.
module skeleton_bone_matrix_compose #(
    parameter int MAX_BONES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    sbmc_bone_if.sink   bone,
    sbmc_mat_if.source  mat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import sbmc_pkg::*;

    localparam int STORE_DEPTH = MAX_BONES * WORDS_PER_BONE;
    localparam int AW          = $clog2(STORE_DEPTH);

    state_t state_reg, state_next;
    logic [5:0] step_reg, step_next;

    logic [6:0] bone_count_reg;
    logic       has_parent_reg;

    logic signed [31:0] scale_reg [3];
    logic signed [31:0] rot_reg   [4];
    logic signed [31:0] pos_reg   [3];
    logic [AW-1:0]      par_base_reg;
    logic [AW-1:0]      slot_base_reg;

    logic signed [PROD_W-1:0] qp_reg  [9];
    logic signed [31:0]       r_reg   [9];
    logic signed [31:0]       loc_reg [9];
    logic signed [31:0]       w_reg   [WORDS_PER_BONE];
    logic signed [SUM_W-1:0]  acc_reg;

    logic       d1_v_reg;
    logic [5:0] d1_tag_reg;
    logic       mr_v_reg;
    logic [5:0] mr_tag_reg;

    logic out_v_reg;
    mat_t out_reg;

    logic [AW-1:0] slot_lut [BONE_SLOTS];

    logic       accept;
    logic       cfg_write;
    logic [5:0] phase_len;
    logic       issue;
    logic       mi_v;
    logic [5:0] mi_tag;
    logic       phase_done;
    logic       out_free;

    logic signed [31:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [SUM_W-1:0]  acc_sum;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    logic          in_has_parent;
    logic [AW-1:0] in_par;
    logic [AW-1:0] in_slot;

    // bone_index folded into the store depth
    for (genvar g = 0; g < BONE_SLOTS; g++)
    begin : g_slot
        assign slot_lut[g] = AW'(g % MAX_BONES);
    end

    assign accept    = bone.valid && bone.ready;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !out_v_reg || mat.ready;

    assign in_has_parent = (bone.data.parent_index < bone_count_reg)
                        && ({25'b0, bone.data.parent_index} < 32'(MAX_BONES));
    assign in_par  = AW'(bone.data.parent_index);
    assign in_slot = slot_lut[bone.data.bone_index];

    // ---------------- sequencer ----------------
    always_comb
    begin
        unique case (state_reg)
            ST_QMUL, ST_LMUL: phase_len = 6'd9;
            ST_WMUL:          phase_len = 6'd48;
            default:          phase_len = 6'd0;
        endcase
    end

    assign issue      = (step_reg < phase_len);
    assign mi_v       = (state_reg == ST_WMUL) ? d1_v_reg : issue;
    assign mi_tag     = (state_reg == ST_WMUL) ? d1_tag_reg : step_reg;
    assign phase_done = (step_reg == phase_len) && !d1_v_reg && !mi_v && !mr_v_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = 6'd0;
                if (bone.valid)
                begin
                    state_next = ST_QMUL;
                end
            end
            ST_QMUL:
            begin
                if (issue)
                begin
                    step_next = step_reg + 6'd1;
                end
                if (phase_done)
                begin
                    state_next = ST_ROT;
                    step_next  = 6'd0;
                end
            end
            ST_ROT:
            begin
                state_next = ST_LMUL;
                step_next  = 6'd0;
            end
            ST_LMUL:
            begin
                if (issue)
                begin
                    step_next = step_reg + 6'd1;
                end
                if (phase_done)
                begin
                    state_next = has_parent_reg ? ST_WMUL : ST_WRITE;
                    step_next  = 6'd0;
                end
            end
            ST_WMUL:
            begin
                if (issue)
                begin
                    step_next = step_reg + 6'd1;
                end
                if (phase_done)
                begin
                    state_next = ST_WRITE;
                    step_next  = 6'd0;
                end
            end
            ST_WRITE:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(WORDS_PER_BONE - 1))
                begin
                    state_next = ST_FLUSH;
                    step_next  = 6'd0;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= 6'd0;
            bone_count_reg <= 7'd1;
            has_parent_reg <= 1'b0;
            d1_v_reg       <= 1'b0;
            mr_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            d1_v_reg  <= issue && (state_reg == ST_WMUL);
            mr_v_reg  <= mi_v;
            if (cfg_write && (paddr[2] == REG_BONE_COUNT))
            begin
                bone_count_reg <= pwdata[6:0];
            end
            if (accept)
            begin
                has_parent_reg <= in_has_parent;
            end
            if ((state_reg == ST_FLUSH) && out_free)
            begin
                out_v_reg <= 1'b1;
            end
            else if (mat.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        logic [1:0] k;
        logic [3:0] wd;
        logic [3:0] lidx;
        k     = mi_tag[1:0];
        wd    = mi_tag[5:2];
        lidx  = {1'b0, k, 1'b0} + {2'b00, k} + {2'b00, col_of(wd)};
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_QMUL:
            begin
                mul_a = rot_reg[qa_sel(mi_tag[3:0])];
                mul_b = rot_reg[qb_sel(mi_tag[3:0])];
            end
            ST_LMUL:
            begin
                mul_a = r_reg[mi_tag[3:0]];
                mul_b = scale_reg[col_of(mi_tag[3:0])];
            end
            ST_WMUL:
            begin
                if (k != K_TRANS)
                begin
                    mul_a = $signed(mem_rdata);
                    mul_b = is_trans(wd) ? pos_reg[k] : loc_reg[lidx];
                end
                else if (is_trans(wd))
                begin
                    // parent translation passes through exactly as P * 1.0
                    mul_a = $signed(mem_rdata);
                    mul_b = ONE_Q16;
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    sbmc_mulq u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign acc_sum = ((mr_tag_reg[1:0] == 2'd0) ? SUM_W'(0) : acc_reg) + SUM_W'(mul_p);

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        d1_tag_reg <= step_reg;
        mr_tag_reg <= mi_tag;

        if (accept)
        begin
            scale_reg[0]  <= bone.data.scale_x;
            scale_reg[1]  <= bone.data.scale_y;
            scale_reg[2]  <= bone.data.scale_z;
            rot_reg[Q_X]  <= bone.data.rot_x;
            rot_reg[Q_Y]  <= bone.data.rot_y;
            rot_reg[Q_Z]  <= bone.data.rot_z;
            rot_reg[Q_W]  <= bone.data.rot_w;
            pos_reg[0]    <= bone.data.pos_x;
            pos_reg[1]    <= bone.data.pos_y;
            pos_reg[2]    <= bone.data.pos_z;
            // root bones keep their own translation
            w_reg[9]      <= bone.data.pos_x;
            w_reg[10]     <= bone.data.pos_y;
            w_reg[11]     <= bone.data.pos_z;
            par_base_reg  <= (in_par << 3) + (in_par << 2);
            slot_base_reg <= (in_slot << 3) + (in_slot << 2);
        end

        if (state_reg == ST_ROT)
        begin
            r_reg[0] <= rot_diag(qp_reg[QP_YY], qp_reg[QP_ZZ]);
            r_reg[1] <= rot_off(qp_reg[QP_XY], qp_reg[QP_WZ], 1'b1);
            r_reg[2] <= rot_off(qp_reg[QP_XZ], qp_reg[QP_WY], 1'b0);
            r_reg[3] <= rot_off(qp_reg[QP_XY], qp_reg[QP_WZ], 1'b0);
            r_reg[4] <= rot_diag(qp_reg[QP_XX], qp_reg[QP_ZZ]);
            r_reg[5] <= rot_off(qp_reg[QP_YZ], qp_reg[QP_WX], 1'b1);
            r_reg[6] <= rot_off(qp_reg[QP_XZ], qp_reg[QP_WY], 1'b1);
            r_reg[7] <= rot_off(qp_reg[QP_YZ], qp_reg[QP_WX], 1'b0);
            r_reg[8] <= rot_diag(qp_reg[QP_XX], qp_reg[QP_YY]);
        end

        if (mr_v_reg)
        begin
            unique case (state_reg)
                ST_QMUL:
                begin
                    qp_reg[mr_tag_reg[3:0]] <= mul_p;
                end
                ST_LMUL:
                begin
                    loc_reg[mr_tag_reg[3:0]] <= sat32(SUM_W'(mul_p));
                    if (!has_parent_reg)
                    begin
                        w_reg[mr_tag_reg[3:0]] <= sat32(SUM_W'(mul_p));
                    end
                end
                ST_WMUL:
                begin
                    acc_reg <= acc_sum;
                    if (mr_tag_reg[1:0] == K_TRANS)
                    begin
                        w_reg[mr_tag_reg[5:2]] <= sat32(acc_sum);
                    end
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end

        if ((state_reg == ST_FLUSH) && out_free)
        begin
            out_reg.m00     <= w_reg[0];
            out_reg.m01     <= w_reg[1];
            out_reg.m02     <= w_reg[2];
            out_reg.m10     <= w_reg[3];
            out_reg.m11     <= w_reg[4];
            out_reg.m12     <= w_reg[5];
            out_reg.m20     <= w_reg[6];
            out_reg.m21     <= w_reg[7];
            out_reg.m22     <= w_reg[8];
            out_reg.trans_x <= w_reg[9];
            out_reg.trans_y <= w_reg[10];
            out_reg.trans_z <= w_reg[11];
        end
    end

    // ---------------- matrix store ----------------
    assign mem_we    = (state_reg == ST_WRITE);
    assign mem_waddr = slot_base_reg + AW'(step_reg[3:0]);
    assign mem_raddr = par_base_reg + AW'(mem_off(step_reg));

    sbmc_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (w_reg[step_reg[3:0]]),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- ports ----------------
    assign bone.ready = (state_reg == ST_IDLE);
    assign mat.valid  = out_v_reg;
    assign mat.data   = out_reg;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_BONE_COUNT) ? {25'b0, bone_count_reg} : 32'd0;

`ifndef SYNTHESIS
    a_no_product_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mr_v_reg |-> (state_reg != ST_IDLE))
        else $error("multiplier result pending while idle");

    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (bone.valid && bone.ready) |-> (!d1_v_reg && !mr_v_reg))
        else $error("bone taken with work still in the multiplier pipe");

    a_out_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> ($past(state_reg) == ST_FLUSH))
        else $error("output valid raised outside the output load");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (step_reg < 6'(WORDS_PER_BONE)))
        else $error("store write step out of range");
`endif

endmodule

[rtl/sbmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sbmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sbmc_mulq.sv]
// Shared s15.16 multiplier: exact product, round half up, registered.
module sbmc_mulq (
    input  logic                               clk,
    input  logic signed [31:0]                 a,
    input  logic signed [31:0]                 b,
    output logic signed [sbmc_pkg::PROD_W-1:0] p
);

    import sbmc_pkg::*;

    logic signed [63:0]       full;
    logic signed [63:0]       rnd;
    logic signed [PROD_W-1:0] p_reg;

    assign full = 64'(a) * 64'(b);
    assign rnd  = full + 64'sd32768;

    // upper bits of the rounded product are the floor over 2^16
    always_ff @(posedge clk)
    begin
        p_reg <= rnd[63:16];
    end

    assign p = p_reg;

endmodule
